// ===== hw/rtl/cobscrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobscrc_pkg: shared types and functions of the COBS / CRC-32K frame decoder
// Holds the error codes, register indexes, CRC-32K octet update and the
// COBS block step used by the frame decoder.
// ----------------------------------------------------------------------------
package cobscrc_pkg;

    // Frame limits and code constants
    localparam int unsigned MAX_DATA_OCTETS  = 2048;
    localparam int unsigned DATA_LEN_W       = 12;
    localparam int unsigned CRC_FIELD_OCTETS = 5;
    localparam int unsigned CRC_VALUE_OCTETS = 4;
    localparam logic [7:0]  CODE_FULL        = 8'd255;
    localparam logic [31:0] CRC_POLY         = 32'hEB31D82E;
    localparam logic [31:0] CRC_INIT         = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_RESIDUE      = 32'h0843323B;

    // Register indexes of the configuration port
    localparam logic CFG_MAX_DATA_LENGTH = 1'b0;
    localparam logic CFG_XOR_MASK        = 1'b1;

    // Frame error codes
    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_ZERO_CODE    = 3'd1,
        ERR_OVERRUN      = 3'd2,
        ERR_TOO_LONG     = 3'd3,
        ERR_EMPTY        = 3'd4,
        ERR_CRC_FIELD    = 3'd5,
        ERR_CRC_MISMATCH = 3'd6
    } err_t;

    // One result item from the decoder to the output register
    typedef struct packed {
        logic                    kind;
        logic [7:0]              data;
        logic                    ok;
        err_t                    err;
        logic [DATA_LEN_W-1:0]   length;
    } result_t;

    // Outcome of one octet through the COBS block machine
    typedef struct packed {
        logic       ok;
        logic       emit;
        logic [7:0] val;
        logic [7:0] remaining;
        logic       full;
        logic       zero_pending;
    } cobs_step_t;

    // Reflected CRC-32K update over one octet, LSB first
    function automatic logic [31:0] crc_update(input logic [31:0] crc_in,
                                               input logic [7:0]  octet);
        logic [31:0] crc;
        logic        mix;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            mix = octet[i] ^ crc[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Advance the COBS block machine by one unmasked octet
    function automatic cobs_step_t cobs_step(input logic [7:0] remaining,
                                             input logic       full,
                                             input logic       zero_pending,
                                             input logic [7:0] dec);
        cobs_step_t r;
        r.ok           = 1'b1;
        r.emit         = 1'b0;
        r.val          = 8'd0;
        r.remaining    = remaining;
        r.full         = full;
        r.zero_pending = zero_pending;
        if (remaining == 8'd0) begin
            if (dec == 8'd0) begin
                r.ok = 1'b0;
            end else begin
                if (zero_pending) begin
                    r.emit         = 1'b1;
                    r.zero_pending = 1'b0;
                end
                r.remaining = dec - 8'd1;
                r.full      = (dec == CODE_FULL);
                if (r.remaining == 8'd0) begin
                    r.zero_pending = ~r.full;
                end
            end
        end else begin
            r.emit      = 1'b1;
            r.val       = dec;
            r.remaining = remaining - 8'd1;
            if (r.remaining == 8'd0) begin
                r.zero_pending = ~full;
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cobscrc_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobscrc_frame: per-frame decode state and combinational octet step
// Holds CRC, COBS block state, counters and the error latch; on each step
// takes one octet and produces at most one result item.
// ----------------------------------------------------------------------------
module cobscrc_frame
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [7:0]                   octet,
    input  logic                         in_crc,
    input  logic                         last,
    input  logic [11:0]                  max_data_length,
    input  logic [7:0]                   xor_mask,
    output logic                         res_valid,
    output cobscrc_pkg::result_t         res
);

    logic [31:0]        crc_reg, crc_next;
    logic [7:0]         remaining_reg, remaining_next;
    logic               full_reg, full_next;
    logic               zp_reg, zp_next;
    logic [11:0]        count_reg, count_next;
    logic [2:0]         crc_oct_reg, crc_oct_next;
    logic [2:0]         crc_dec_reg, crc_dec_next;
    cobscrc_pkg::err_t  err_reg, err_next;

    logic [7:0]             dec;
    logic [11:0]            limit;
    logic                   have_data;
    logic                   zp_work;
    cobscrc_pkg::cobs_step_t cs;
    cobscrc_pkg::err_t      err_final;

    assign dec   = octet ^ xor_mask;
    assign limit = (max_data_length > 12'(cobscrc_pkg::MAX_DATA_OCTETS))
                 ? 12'(cobscrc_pkg::MAX_DATA_OCTETS) : max_data_length;

    // Step the frame state by one octet and form the result item
    always_comb
    begin
        crc_next       = crc_reg;
        remaining_next = remaining_reg;
        full_next      = full_reg;
        zp_next        = zp_reg;
        count_next     = count_reg;
        crc_oct_next   = crc_oct_reg;
        crc_dec_next   = crc_dec_reg;
        err_next       = err_reg;
        have_data      = 1'b0;
        zp_work        = zp_reg;
        err_final      = cobscrc_pkg::ERR_NONE;
        cs = cobscrc_pkg::cobs_step(remaining_reg, full_reg, zp_reg, dec);

        if (err_reg == cobscrc_pkg::ERR_NONE) begin
            if (!in_crc) begin
                if (crc_oct_reg != 3'd0) begin
                    err_next = cobscrc_pkg::ERR_CRC_FIELD;
                end else begin
                    crc_next = cobscrc_pkg::crc_update(crc_reg, octet);
                    if (!cs.ok) begin
                        err_next = cobscrc_pkg::ERR_ZERO_CODE;
                    end else begin
                        remaining_next = cs.remaining;
                        full_next      = cs.full;
                        zp_next        = cs.zero_pending;
                        if (cs.emit) begin
                            if (count_reg >= limit) begin
                                err_next = cobscrc_pkg::ERR_TOO_LONG;
                            end else begin
                                count_next = count_reg + 12'd1;
                                have_data  = 1'b1;
                            end
                        end
                    end
                end
            end else begin
                // Check the data field ends cleanly; drop its trailing zero
                if (crc_oct_reg == 3'd0) begin
                    if (remaining_reg != 8'd0) begin
                        err_next = cobscrc_pkg::ERR_OVERRUN;
                    end else if (count_reg == 12'd0) begin
                        err_next = cobscrc_pkg::ERR_EMPTY;
                    end else begin
                        zp_work = 1'b0;
                    end
                end
                cs = cobscrc_pkg::cobs_step(remaining_reg, full_reg, zp_work, dec);
                zp_next = zp_work;
                if (err_next == cobscrc_pkg::ERR_NONE) begin
                    if (crc_oct_reg >= 3'(cobscrc_pkg::CRC_FIELD_OCTETS)) begin
                        err_next = cobscrc_pkg::ERR_CRC_FIELD;
                    end else begin
                        crc_oct_next = crc_oct_reg + 3'd1;
                        if (!cs.ok) begin
                            err_next = cobscrc_pkg::ERR_CRC_FIELD;
                        end else begin
                            remaining_next = cs.remaining;
                            full_next      = cs.full;
                            zp_next        = cs.zero_pending;
                            if (cs.emit) begin
                                if (crc_dec_reg >= 3'(cobscrc_pkg::CRC_VALUE_OCTETS)) begin
                                    err_next = cobscrc_pkg::ERR_CRC_FIELD;
                                end else begin
                                    crc_dec_next = crc_dec_reg + 3'd1;
                                    crc_next = cobscrc_pkg::crc_update(crc_reg, cs.val);
                                end
                            end
                        end
                    end
                end
            end
        end

        // Judge the frame at its last octet
        err_final = err_next;
        if (err_next == cobscrc_pkg::ERR_NONE) begin
            if (crc_oct_next == 3'd0) begin
                if (remaining_next != 8'd0) begin
                    err_final = cobscrc_pkg::ERR_OVERRUN;
                end else if (count_next == 12'd0) begin
                    err_final = cobscrc_pkg::ERR_EMPTY;
                end else begin
                    err_final = cobscrc_pkg::ERR_CRC_FIELD;
                end
            end else if (crc_oct_next != 3'(cobscrc_pkg::CRC_FIELD_OCTETS)
                         || remaining_next != 8'd0
                         || crc_dec_next != 3'(cobscrc_pkg::CRC_VALUE_OCTETS)) begin
                err_final = cobscrc_pkg::ERR_CRC_FIELD;
            end else if (crc_next != cobscrc_pkg::CRC_RESIDUE) begin
                err_final = cobscrc_pkg::ERR_CRC_MISMATCH;
            end
        end

        // Form the result item
        res_valid  = last | have_data;
        res.kind   = last;
        res.data   = last ? 8'd0 : cs.val;
        res.ok     = last && (err_final == cobscrc_pkg::ERR_NONE);
        res.err    = last ? err_final : cobscrc_pkg::ERR_NONE;
        res.length = (last && err_final == cobscrc_pkg::ERR_NONE) ? count_next : 12'd0;

        // Clear all frame state after the status item
        if (last) begin
            crc_next       = cobscrc_pkg::CRC_INIT;
            remaining_next = 8'd0;
            full_next      = 1'b0;
            zp_next        = 1'b0;
            count_next     = 12'd0;
            crc_oct_next   = 3'd0;
            crc_dec_next   = 3'd0;
            err_next       = cobscrc_pkg::ERR_NONE;
        end
    end

    // Hold the frame state between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg       <= cobscrc_pkg::CRC_INIT;
            remaining_reg <= 8'd0;
            full_reg      <= 1'b0;
            zp_reg        <= 1'b0;
            count_reg     <= 12'd0;
            crc_oct_reg   <= 3'd0;
            crc_dec_reg   <= 3'd0;
            err_reg       <= cobscrc_pkg::ERR_NONE;
        end else if (step) begin
            crc_reg       <= crc_next;
            remaining_reg <= remaining_next;
            full_reg      <= full_next;
            zp_reg        <= zp_next;
            count_reg     <= count_next;
            crc_oct_reg   <= crc_oct_next;
            crc_dec_reg   <= crc_dec_next;
            err_reg       <= err_next;
        end
    end

endmodule

// ===== hw/rtl/cobs_crc32k_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_crc32k_frame_decoder: COBS frame decoder with CRC-32K check
// Takes one received octet per item and returns decoded data octets and
// one end-of-frame status item per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries encoded_octet, crc_field and
//   frame_end. Output channel (out_valid / out_stall) carries result_kind,
//   data_octet, frame_ok, error_code and decoded_length. Each item is moved
//   at a clock edge with valid high and stall low.
//   An item is captured in an input register, stepped through the frame
//   state once the output register can take a result and lands in the
//   output register. The frame state update is combinational (CRC-32K
//   octet update plus COBS counters) and loops through the frame registers,
//   so one item is taken every cycle while the output is drained.
//   If the receiver stalls, the output register holds its item and the
//   input register fills; in_stall is high only while both are occupied and
//   the receiver stalls.
//   Reset clears the frame state, empties both registers and loads
//   max_data_length = 1497 and xor_mask = 0x55. The user must write
//   configuration through cfg_we / cfg_index / cfg_data only while no
//   frame is in flight; the block does not enforce this. Data octets of a
//   frame whose status reports failure must be dropped downstream.
// ----------------------------------------------------------------------------
module cobs_crc32k_frame_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  encoded_octet,
    input  logic        crc_field,
    input  logic        frame_end,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  data_octet,
    output logic        frame_ok,
    output logic [2:0]  error_code,
    output logic [11:0] decoded_length
);

    logic [11:0]          max_len_reg;
    logic [7:0]           mask_reg;

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           octet_reg;
    logic                 crc_field_reg;
    logic                 frame_end_reg;

    logic                 out_valid_reg, out_valid_next;
    cobscrc_pkg::result_t out_reg;

    logic                 fire;
    logic                 accept;
    logic                 res_valid;
    cobscrc_pkg::result_t res;

    // Step when an item is held and the output register can take a result
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg <= 12'd1497;
            mask_reg    <= 8'h55;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cobscrc_pkg::CFG_MAX_DATA_LENGTH: max_len_reg <= cfg_data;
                cobscrc_pkg::CFG_XOR_MASK:        mask_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Advance the input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            octet_reg     <= encoded_octet;
            crc_field_reg <= crc_field;
            frame_end_reg <= frame_end;
        end
    end

    // Decode one item per cycle while the output register can take a result
    cobscrc_frame u_frame
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (fire),
        .octet           (octet_reg),
        .in_crc          (crc_field_reg),
        .last            (frame_end_reg),
        .max_data_length (max_len_reg),
        .xor_mask        (mask_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = res_valid;
        end else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_reg.kind;
    assign data_octet     = out_reg.data;
    assign frame_ok       = out_reg.ok;
    assign error_code     = out_reg.err;
    assign decoded_length = out_reg.length;

endmodule
